// ===== rtl/cbfp_pkg.sv =====
`timescale 1ns / 1ps

package cbfp_pkg;

	localparam int NUM_SLOTS = 5;

	// Configuration register indexes
	localparam logic [7:0] REG_LEGACY_HOST_MODE = 8'd0;
	localparam logic [7:0] REG_RECEIVE_ENABLE   = 8'd1;

	// Command codes
	localparam logic [7:0] CMD_CHAR_B      = 8'h62;
	localparam logic [7:0] CMD_CHAR_S      = 8'h73;
	localparam logic [7:0] CMD_DOT         = 8'h2E;
	localparam logic [7:0] CMD_CHAR_UPPERZ = 8'h5A;
	localparam logic [7:0] CMD_CHAR_Z      = 8'h7A;
	localparam logic [7:0] CMD_CHAR_V      = 8'h76;
	localparam logic [7:0] CMD_H30         = 8'h30;
	localparam logic [7:0] CMD_H31         = 8'h31;
	localparam logic [7:0] CMD_H32         = 8'h32;
	localparam logic [7:0] CMD_H41         = 8'h41;
	localparam logic [7:0] CMD_CHAR_P      = 8'h70;
	localparam logic [7:0] CMD_CHAR_D      = 8'h64;
	localparam logic [7:0] CMD_H10         = 8'h10;
	localparam logic [7:0] CMD_H12         = 8'h12;
	localparam logic [7:0] CMD_H13         = 8'h13;
	localparam logic [7:0] CMD_H14         = 8'h14;
	localparam logic [7:0] CMD_H20         = 8'h20;
	localparam logic [7:0] CMD_H21         = 8'h21;
	localparam logic [7:0] CMD_H40         = 8'h40;
	localparam logic [7:0] CMD_H11         = 8'h11;
	localparam logic [7:0] CMD_TIME_SYNC   = 8'h74;

	typedef struct packed {
		logic       known;
		logic [2:0] len;
	} code_info_t;

	typedef struct packed {
		logic [7:0]                command_code;
		logic [2:0]                payload_length;
		logic [NUM_SLOTS-1:0][7:0] payload;
	} frame_t;

	function automatic code_info_t lookup_code(input logic [7:0] code, input logic legacy);
		code_info_t info;
		info.known = 1'b1;
		info.len   = 3'd0;
		case (code)
			CMD_CHAR_B, CMD_CHAR_S, CMD_DOT, CMD_CHAR_UPPERZ, CMD_CHAR_Z, CMD_CHAR_V,
			CMD_H30, CMD_H31, CMD_H32, CMD_H41: info.len = 3'd0;
			CMD_CHAR_P, CMD_CHAR_D, CMD_H10, CMD_H12, CMD_H13, CMD_H14,
			CMD_H20, CMD_H21, CMD_H40: info.len = 3'd1;
			CMD_H11: info.len = 3'd2;
			CMD_TIME_SYNC: info.len = legacy ? 3'd4 : 3'd5;
			default: info.known = 1'b0;
		endcase
		return info;
	endfunction

endpackage

// ===== rtl/cbfp_assembler.sv =====
`timescale 1ns / 1ps

module cbfp_assembler import cbfp_pkg::*; #(
	parameter int MAX_PAYLOAD = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic       legacy_host_mode,
	input  logic       receive_enable,
	output logic       emit,
	output frame_t     frame
);

	localparam int IW = $clog2(MAX_PAYLOAD);

	logic             collecting_q;
	logic [7:0]       code_q;
	logic [IW-1:0]    gathered_q;
	logic [2:0]       expected_q;
	logic [7:0]       store_q [MAX_PAYLOAD];

	code_info_t       info;
	logic             take;
	logic             gather;
	logic [IW:0]      gathered_inc;
	logic             done;

	assign info         = lookup_code(rx_byte, legacy_host_mode);
	assign take         = step && receive_enable;
	assign gather       = take && collecting_q;
	assign gathered_inc = {1'b0, gathered_q} + (IW+1)'(1);
	assign done         = gathered_inc >= (IW+1)'(expected_q);

	always_comb begin
		emit                 = 1'b0;
		frame.command_code   = code_q;
		frame.payload_length = expected_q;
		frame.payload        = '0;
		if (take && !collecting_q) begin
			// zero-length command closes on its own code byte
			emit                 = info.known && (info.len == 3'd0);
			frame.command_code   = rx_byte;
			frame.payload_length = 3'd0;
		end else if (gather && done) begin
			emit = 1'b1;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (3'(i) < expected_q) begin
					// last byte bypasses the store
					frame.payload[i] = (IW'(i) == gathered_q) ? rx_byte : store_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			code_q       <= '0;
			gathered_q   <= '0;
			expected_q   <= '0;
		end else if (take) begin
			if (!collecting_q) begin
				if (info.known) begin
					code_q       <= rx_byte;
					gathered_q   <= '0;
					expected_q   <= info.len;
					collecting_q <= (info.len != 3'd0);
				end
			end else if (done) begin
				collecting_q <= 1'b0;
				gathered_q   <= '0;
				expected_q   <= '0;
			end else begin
				gathered_q <= gathered_inc[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gather) begin
			store_q[gathered_q] <= rx_byte;
		end
	end

endmodule

// ===== rtl/command_byte_frame_parser.sv =====
`timescale 1ns / 1ps

// Command byte frame parser. Received bytes enter one word per cycle on the
// in channel while in_stall is low. While idle, a byte is taken as a command
// code and looked up for its payload length (0, 1, 2, 4 or 5 bytes; time
// sync 0x74 carries 4 bytes in legacy host mode and 5 otherwise); unknown
// codes are dropped with no result. Payload bytes are then gathered until the
// frame is complete, and one result word carries the code, the payload length
// and five payload slots, unused slots zero. A zero-length command yields its
// result on the code byte itself. Throughput is one byte per cycle while
// in_stall is low: the byte is registered, the lookup and frame update are
// combinational, and the result is registered. in_stall rises only while a
// byte waits behind a result held by out_stall. Configuration: index 0
// legacy_host_mode (reset 0), index 1 receive_enable (reset 1; when 0 bytes
// are taken and ignored, a partial frame is kept). Other indexes are ignored.
// Write configuration only while the block is idle.
module command_byte_frame_parser import cbfp_pkg::*; #(
	parameter int MAX_PAYLOAD = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	// input byte channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] command_code,
	output logic [2:0] payload_length,
	output logic [7:0] payload_byte_0,
	output logic [7:0] payload_byte_1,
	output logic [7:0] payload_byte_2,
	output logic [7:0] payload_byte_3,
	output logic [7:0] payload_byte_4,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic       legacy_q;
	logic       enable_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	frame_t     frame_s2;
	logic       advance;
	logic       accept;
	logic       emit;
	frame_t     frame;

	// Advance the registered byte whenever the result register can take a word.
	assign advance   = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			legacy_q <= 1'b0;
			enable_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LEGACY_HOST_MODE: legacy_q <= cfg_data[0];
				REG_RECEIVE_ENABLE:   enable_q <= cfg_data[0];
				default:              ;
			endcase
		end
	end

	// Input register: load on accept, drop once processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	cbfp_assembler #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_assembler (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.rx_byte          (byte_s1),
		.legacy_host_mode (legacy_q),
		.receive_enable   (enable_q),
		.emit             (emit),
		.frame            (frame)
	);

	// Result register: hold while stalled, replace or clear otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			frame_s2 <= frame;
		end
	end

	assign out_valid      = valid_s2;
	assign command_code   = frame_s2.command_code;
	assign payload_length = frame_s2.payload_length;
	assign payload_byte_0 = frame_s2.payload[0];
	assign payload_byte_1 = frame_s2.payload[1];
	assign payload_byte_2 = frame_s2.payload[2];
	assign payload_byte_3 = frame_s2.payload[3];
	assign payload_byte_4 = frame_s2.payload[4];

endmodule
